// ----- rtl/tbps_pkg.sv -----
// ----------------------------------------------------------------------------
// tbps_pkg: shared types and constants
// Field widths, action and mode codes, register indexes and the bundles
// that pass between the sequencer's submodules.
// ----------------------------------------------------------------------------
package tbps_pkg;

    localparam int DEF_SHIFTER_BITS = 32;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 12;
    localparam int COLOR_W  = 4;
    localparam int MODE_W   = 3;
    localparam int SCROLL_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // item actions
    localparam logic [ACTION_W-1:0] ACT_LINE_START = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD       = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PIXEL      = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RESERVED   = 2'd3;

    // display modes: {extended color, bitmap, multicolor}
    localparam logic [MODE_W-1:0] MODE_STD_TEXT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MC_TEXT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STD_BMP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MC_BMP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ECM_TEXT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR_3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_H_SCROLL     = 3'd5;

    // matrix word: multicolor-enable bit of the color nibble
    localparam int MC_FLAG_BIT = 11;

    typedef struct packed {
        logic [MODE_W-1:0]               display_mode;
        logic [3:0][COLOR_W-1:0]         bkg_color;
        logic [SCROLL_W-1:0]             h_scroll;
    } cfg_t;

    // command from the control stage to the shifter
    typedef struct packed {
        logic              line_start;
        logic              load;
        logic [1:0]        take_n;
        logic [BYTE_W-1:0] gbyte;
        logic [WORD_W-1:0] mword;
    } shift_cmd_t;

    // what the pixel decoder sees of the shifter
    typedef struct packed {
        logic [1:0]        head_bits;
        logic [WORD_W-1:0] mword;
    } shift_view_t;

endpackage

// ----- rtl/tbps_if.sv -----
// ----------------------------------------------------------------------------
// tbps_if: valid/ready channels of the pixel sequencer
// Request channel carries action items, result channel carries pixels.
// ----------------------------------------------------------------------------
interface tbps_req_if
    import tbps_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   graphics_byte;
    logic [WORD_W-1:0]   matrix_word;
    logic                pixel_odd;

    modport source (
        output valid, action, graphics_byte, matrix_word, pixel_odd,
        input  ready
    );
    modport sink (
        input  valid, action, graphics_byte, matrix_word, pixel_odd,
        output ready
    );
endinterface

interface tbps_rsp_if
    import tbps_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic               foreground_pixel;

    modport source (
        output valid, pixel_color, foreground_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, foreground_pixel,
        output ready
    );
endinterface

// ----- rtl/text_bitmap_pixel_sequencer.sv -----
// ----------------------------------------------------------------------------
// text_bitmap_pixel_sequencer: background graphics pixel sequencer
// Line-start, load and pixel items drive a pixel shifter; pixel items
// return a palette index and foreground flag.
// ----------------------------------------------------------------------------
// A pixel item passes through the input register, then the result register,
//   before its result is shown on rsp.
// Throughput: one item per cycle, any mix of actions; the input register
//   keeps taking items while a result waits, stalling only when both are full.
// Reset: rst_n clears shifter, count, latched word, held color and all
//   configuration registers at once; no clearing pass.
module text_bitmap_pixel_sequencer
    import tbps_pkg::*;
#(
    parameter int SHIFTER_BITS = DEF_SHIFTER_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tbps_req_if.sink              req,
    tbps_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ---- input register ---------------------------------------------------
    logic                in_valid_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [BYTE_W-1:0]   gbyte_reg;
    logic [WORD_W-1:0]   mword_reg;
    logic                odd_reg;

    // ---- result register --------------------------------------------------
    logic                out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]  color_reg;
    logic                fg_reg;

    logic               advance;      // the item in the input register moves on
    logic               proc_pixel;
    cfg_t               cfg;
    shift_cmd_t         cmd;
    shift_view_t        view;
    logic [1:0]         take_n;
    logic [COLOR_W-1:0] pix_color;
    logic               pix_fg;

    // The result register is free when empty or being drained this cycle.
    // Items without a result (line start, load) still pass through it as a
    // bubble, which keeps the result order trivially intact.
    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            action_reg <= req.action;
            gbyte_reg  <= req.graphics_byte;
            mword_reg  <= req.matrix_word;
            odd_reg    <= req.pixel_odd;
        end
    end

    tbps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // State only moves when the item leaves the input register, so the
    // next item always sees the state this one leaves behind.
    assign proc_pixel     = in_valid_reg && advance && (action_reg == ACT_PIXEL);
    assign cmd.line_start = in_valid_reg && advance && (action_reg == ACT_LINE_START);
    assign cmd.load       = in_valid_reg && advance && (action_reg == ACT_LOAD);
    assign cmd.take_n     = take_n;
    assign cmd.gbyte      = gbyte_reg;
    assign cmd.mword      = mword_reg;

    tbps_shifter #(
        .SHIFTER_BITS (SHIFTER_BITS)
    ) u_shifter (
        .clk      (clk),
        .rst_n    (rst_n),
        .h_scroll (cfg.h_scroll),
        .cmd      (cmd),
        .view     (view)
    );

    tbps_pixel u_pixel (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (proc_pixel),
        .pixel_odd (odd_reg),
        .cfg       (cfg),
        .view      (view),
        .take_n    (take_n),
        .color     (pix_color),
        .fg        (pix_fg)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = proc_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_pixel)
        begin
            color_reg <= pix_color;
            fg_reg    <= pix_fg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.pixel_color      = color_reg;
    assign rsp.foreground_pixel = fg_reg;

`ifndef SYNTHESIS
    // a pixel item that moves on always produces a result
    a_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc_pixel |=> out_valid_reg)
        else $error("pixel item produced no result");

    // an item without a result never raises the result valid
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance && (action_reg != ACT_PIXEL)) |=> !out_valid_reg)
        else $error("non-pixel item produced a result");
`endif

endmodule

// ----- rtl/tbps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tbps_cfg_regs: configuration register file
// Write-only mode, background color and fine scroll registers.
// ----------------------------------------------------------------------------
module tbps_cfg_regs
    import tbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DISPLAY_MODE: cfg_reg.display_mode <= cfg_data[MODE_W-1:0];
                REG_BG_COLOR_0:   cfg_reg.bkg_color[0] <= cfg_data[COLOR_W-1:0];
                REG_BG_COLOR_1:   cfg_reg.bkg_color[1] <= cfg_data[COLOR_W-1:0];
                REG_BG_COLOR_2:   cfg_reg.bkg_color[2] <= cfg_data[COLOR_W-1:0];
                REG_BG_COLOR_3:   cfg_reg.bkg_color[3] <= cfg_data[COLOR_W-1:0];
                REG_H_SCROLL:     cfg_reg.h_scroll     <= cfg_data[SCROLL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/tbps_shifter.sv -----
// ----------------------------------------------------------------------------
// tbps_shifter: pixel shifter and pending-bit count
// Appends fetched bytes behind the pending bits, shifts out one or two
// bits per pixel and latches the matrix word.
// ----------------------------------------------------------------------------
module tbps_shifter
    import tbps_pkg::*;
#(
    parameter int SHIFTER_BITS = DEF_SHIFTER_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SCROLL_W-1:0] h_scroll,
    input  shift_cmd_t          cmd,
    output shift_view_t         view
);

    localparam int CntW = $clog2(SHIFTER_BITS + 1);

    logic [SHIFTER_BITS-1:0] shift_reg, shift_next;
    logic [CntW-1:0]         count_reg, count_next;
    logic [WORD_W-1:0]       mword_reg, mword_next;

    logic [BYTE_W-1:0]       rev_byte;
    logic [SHIFTER_BITS-1:0] rev_placed;
    logic [CntW:0]           count_sum;

    // first pixel of the byte is its top bit, so it goes out first
    always_comb
    begin
        for (int i = 0; i < BYTE_W; i++)
        begin
            rev_byte[i] = cmd.gbyte[BYTE_W-1-i];
        end
    end

    assign rev_placed = SHIFTER_BITS'(rev_byte) << count_reg;
    assign count_sum  = {1'b0, count_reg} + (CntW+1)'(BYTE_W);

    always_comb
    begin
        shift_next = shift_reg;
        count_next = count_reg;
        mword_next = mword_reg;
        if (cmd.line_start)
        begin
            shift_next = '0;
            count_next = CntW'(h_scroll);
        end
        else if (cmd.load)
        begin
            if (count_reg < CntW'(SHIFTER_BITS))
            begin
                shift_next = shift_reg | rev_placed;
            end
            count_next = (count_sum > (CntW+1)'(SHIFTER_BITS)) ?
                         CntW'(SHIFTER_BITS) : count_sum[CntW-1:0];
            mword_next = cmd.mword;
        end
        else if (cmd.take_n != 2'd0)
        begin
            shift_next = shift_reg >> cmd.take_n;
            count_next = (count_reg > CntW'(cmd.take_n)) ?
                         count_reg - CntW'(cmd.take_n) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            count_reg <= '0;
            mword_reg <= '0;
        end
        else
        begin
            shift_reg <= shift_next;
            count_reg <= count_next;
            mword_reg <= mword_next;
        end
    end

    assign view.head_bits = shift_reg[1:0];
    assign view.mword     = mword_reg;

`ifndef SYNTHESIS
    // count saturates at the shifter width
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(SHIFTER_BITS))
        else $error("pending bit count beyond shifter width");

    // line start presets the count to the fine scroll
    a_line_preset: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.line_start |=> count_reg == CntW'($past(h_scroll)))
        else $error("line start did not preset pending count");
`endif

endmodule

// ----- rtl/tbps_pixel.sv -----
// ----------------------------------------------------------------------------
// tbps_pixel: background pixel decoder
// Maps the head of the shifter to a palette index and foreground flag per
// display mode; holds color on odd pixels of the two-bit modes.
// ----------------------------------------------------------------------------
module tbps_pixel
    import tbps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic               pixel_odd,
    input  cfg_t               cfg,
    input  shift_view_t        view,
    output logic [1:0]         take_n,
    output logic [COLOR_W-1:0] color,
    output logic               fg
);

    logic [COLOR_W-1:0] held_color_reg, held_color_next;
    logic               held_fg_reg, held_fg_next;

    logic [WORD_W-1:0]  m;
    logic               px;
    logic [1:0]         pair;
    logic [COLOR_W-1:0] nib_hi, nib_mid, nib_lo, nib_mc;
    logic               two_bit;
    logic [1:0]         take_raw;

    assign m       = view.mword;
    assign px      = view.head_bits[0];
    assign pair    = {view.head_bits[0], view.head_bits[1]};
    assign nib_hi  = m[11:8];
    assign nib_mid = m[7:4];
    assign nib_lo  = m[3:0];
    assign nib_mc  = {1'b0, m[10:8]};

    assign two_bit = (cfg.display_mode == MODE_MC_BMP) ||
                     ((cfg.display_mode == MODE_MC_TEXT) && m[MC_FLAG_BIT]);

    always_comb
    begin
        color           = '0;
        fg              = 1'b0;
        take_raw        = 2'd0;
        held_color_next = held_color_reg;
        held_fg_next    = held_fg_reg;
        if (two_bit)
        begin
            if (!pixel_odd)
            begin
                held_fg_next = pair[1];
                if (cfg.display_mode == MODE_MC_TEXT)
                begin
                    held_color_next = (pair == 2'd3) ? nib_mc : cfg.bkg_color[pair];
                end
                else
                begin
                    case (pair)
                        2'd0:    held_color_next = cfg.bkg_color[0];
                        2'd1:    held_color_next = nib_mid;
                        2'd2:    held_color_next = nib_lo;
                        default: held_color_next = nib_hi;
                    endcase
                end
                take_raw = 2'd2;
            end
            color = held_color_next;
            fg    = held_fg_next;
        end
        else
        begin
            case (cfg.display_mode)
                MODE_STD_TEXT:
                begin
                    color    = px ? nib_hi : cfg.bkg_color[0];
                    fg       = px;
                    take_raw = 2'd1;
                end
                MODE_MC_TEXT:
                begin
                    color    = px ? nib_mc : cfg.bkg_color[0];
                    fg       = px;
                    take_raw = 2'd1;
                end
                MODE_STD_BMP:
                begin
                    color    = px ? nib_mid : nib_lo;
                    fg       = px;
                    take_raw = 2'd1;
                end
                MODE_ECM_TEXT:
                begin
                    color    = px ? nib_hi : cfg.bkg_color[m[7:6]];
                    fg       = px;
                    take_raw = 2'd1;
                end
                default:
                begin
                    color    = '0;
                    fg       = 1'b0;
                    take_raw = 2'd0;
                end
            endcase
        end
    end

    assign take_n = go ? take_raw : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_color_reg <= '0;
            held_fg_reg    <= 1'b0;
        end
        else if (go)
        begin
            held_color_reg <= held_color_next;
            held_fg_reg    <= held_fg_next;
        end
    end

endmodule
